@@ hw/rtl/grm_pkg.sv @@
// ----------------------------------------------------------------------------
// grm_pkg
// Shared widths, constants, register and status codes and the ray record for
// the grid ray march unit.
// ----------------------------------------------------------------------------
package grm_pkg;

    localparam int MAP_SIZE        = 16;
    localparam int CELL_SIZE_DEF   = 64;
    localparam int MAX_STEPS_DEF   = 2047;
    localparam int ANGLE_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int ORIGIN_W   = 10;
    localparam int VIEW_W     = 12;
    localparam int COLUMN_W   = 10;
    localparam int HIT_W      = 16;
    localparam int DIST_W     = 11;
    localparam int STATUS_W   = 2;
    localparam int FOV_W      = 12;
    localparam int COUNT_W    = 11;
    localparam int MAP_W      = 64;
    localparam int MAP_REGS   = 4;
    localparam int WALL_W     = MAP_REGS * MAP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SUBPIX_W   = 6;
    localparam int TRIG_W     = 16;
    localparam int MAG_W      = 15;
    localparam int FRAC_W     = 14;
    localparam int DIVIDEND_W = COLUMN_W + FOV_W;

    localparam logic [FOV_W-1:0]   FOV_RESET   = 12'd652;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd512;
    localparam logic [MAG_W-1:0]   Q14_ONE     = 15'd16384;

    // quarter-wave sine polynomial coefficients, Q14
    localparam logic [TRIG_W-1:0] POLY_C0 = 16'd77;
    localparam logic [TRIG_W-1:0] POLY_C1 = 16'd1306;
    localparam logic [TRIG_W-1:0] POLY_C2 = 16'd10583;
    localparam logic [TRIG_W-1:0] POLY_C3 = 16'd25736;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_0   = 3'd0,
        REG_MAP_1   = 3'd1,
        REG_MAP_2   = 3'd2,
        REG_MAP_3   = 3'd3,
        REG_FOV     = 3'd4,
        REG_COLUMNS = 3'd5
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_WALL       = 2'd0,
        ST_LEFT_MAP   = 2'd1,
        ST_STEP_LIMIT = 2'd2
    } status_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0]      origin_x;
        logic [ORIGIN_W-1:0]      origin_y;
        logic signed [TRIG_W-1:0] sin_q14;
        logic signed [TRIG_W-1:0] cos_q14;
    } ray_t;

endpackage

@@ hw/rtl/grm_channels.sv @@
// ----------------------------------------------------------------------------
// grm channels
// Valid/ready channels for ray requests and march results.
// ----------------------------------------------------------------------------
interface grm_req_if;
    logic                          valid;
    logic                          ready;
    logic [grm_pkg::ORIGIN_W-1:0]  origin_x;
    logic [grm_pkg::ORIGIN_W-1:0]  origin_y;
    logic [grm_pkg::VIEW_W-1:0]    view_angle;
    logic [grm_pkg::COLUMN_W-1:0]  column;

    modport source (output valid, output origin_x, output origin_y,
                    output view_angle, output column, input ready);
    modport sink   (input valid, input origin_x, input origin_y,
                    input view_angle, input column, output ready);
endinterface

interface grm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [grm_pkg::HIT_W-1:0]     hit_x;
    logic [grm_pkg::HIT_W-1:0]     hit_y;
    logic [grm_pkg::DIST_W-1:0]    distance;
    logic [grm_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output hit_x, output hit_y,
                    output distance, output status, input ready);
    modport sink   (input valid, input hit_x, input hit_y,
                    input distance, input status, output ready);
endinterface

@@ hw/rtl/grm_front.sv @@
// ----------------------------------------------------------------------------
// grm_front
// Takes a ray request, works out the ray angle with a bit-serial divider and
// evaluates sine and cosine on one shared multiplier.
// ----------------------------------------------------------------------------
module grm_front #(
    parameter int ANGLE_BITS = grm_pkg::ANGLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    grm_req_if.sink                     req,
    input  logic [grm_pkg::FOV_W-1:0]   fov_span,
    input  logic [grm_pkg::COUNT_W-1:0] column_count,
    output grm_pkg::ray_t               ray,
    output logic                        ray_valid,
    input  logic                        ray_ready
);

    localparam int DW      = grm_pkg::DIVIDEND_W;
    localparam int CW      = grm_pkg::COUNT_W;
    localparam int TW      = grm_pkg::TRIG_W;
    localparam int MW      = grm_pkg::MAG_W;
    localparam int ITER_W  = $clog2(DW);
    localparam int QBITS   = ANGLE_BITS - 2;
    localparam int XSHIFT  = 16 - ANGLE_BITS;
    localparam int SUM_W   = 16;
    localparam logic [ITER_W-1:0]     ITER_LAST = ITER_W'(DW - 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1) << QBITS;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_ANGLE,
        F_PREP,
        F_POLY,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        P_SQUARE,
        P_TERM0,
        P_TERM1,
        P_TERM2,
        P_SCALE
    } poly_step_t;

    front_state_t state_reg, state_next;
    poly_step_t   step_reg, step_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              phase_reg, phase_next;

    logic [grm_pkg::ORIGIN_W-1:0] ox_reg, ox_next;
    logic [grm_pkg::ORIGIN_W-1:0] oy_reg, oy_next;
    logic [grm_pkg::VIEW_W-1:0]   view_reg, view_next;
    logic [DW-1:0]                dividend_reg, dividend_next;
    logic [CW-1:0]                rem_reg, rem_next;
    logic [ANGLE_BITS-1:0]        quot_reg, quot_next;
    logic [ANGLE_BITS-1:0]        angle_reg, angle_next;
    logic [MW-1:0]                x_reg, x_next;
    logic [MW-1:0]                x2_reg, x2_next;
    logic [TW-1:0]                t_reg, t_next;
    logic                         neg_reg, neg_next;
    logic signed [TW-1:0]         sin_reg, sin_next;
    logic signed [TW-1:0]         cos_reg, cos_next;

    logic [CW-1:0]         divisor;
    logic [CW:0]           rem_shift;
    logic                  rem_ge;
    logic [SUM_W-1:0]      angle_sum;
    logic [ANGLE_BITS-1:0] cur_angle;
    logic [MW-1:0]         x_frac;
    logic [TW-1:0]         mul_a;
    logic [MW-1:0]         mul_b;
    logic [TW+MW-1:0]      mul_p;
    logic [TW-1:0]         mul_q;
    logic [MW-1:0]         mag;
    logic signed [TW-1:0]  trig;

    assign divisor   = (column_count == '0) ? CW'(1) : column_count;
    assign rem_shift = {rem_reg, dividend_reg[DW-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor};

    assign angle_sum = SUM_W'(view_reg) - SUM_W'(fov_span[grm_pkg::FOV_W-1:1])
                     + SUM_W'(quot_reg);

    assign cur_angle = phase_reg ? angle_reg + QUARTER : angle_reg;
    assign x_frac    = MW'(cur_angle[QBITS-1:0]) << XSHIFT;

    always_comb
    begin
        case (step_reg)
            P_SQUARE:
            begin
                mul_a = TW'(x_reg);
                mul_b = x_reg;
            end
            P_TERM0:
            begin
                mul_a = grm_pkg::POLY_C0;
                mul_b = x2_reg;
            end
            P_SCALE:
            begin
                mul_a = t_reg;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = x2_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign mul_q = mul_p[grm_pkg::FRAC_W +: TW];
    assign mag   = (mul_q > TW'(grm_pkg::Q14_ONE)) ? grm_pkg::Q14_ONE : mul_q[MW-1:0];
    assign trig  = neg_reg ? -$signed(TW'(mag)) : $signed(TW'(mag));

    assign req.ready = (state_reg == F_IDLE);
    assign ray_valid = (state_reg == F_PUSH);
    assign ray       = '{origin_x: ox_reg, origin_y: oy_reg,
                         sin_q14: sin_reg, cos_q14: cos_reg};

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        iter_next     = iter_reg;
        phase_next    = phase_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        view_next     = view_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        angle_next    = angle_reg;
        x_next        = x_reg;
        x2_next       = x2_reg;
        t_next        = t_reg;
        neg_next      = neg_reg;
        sin_next      = sin_reg;
        cos_next      = cos_reg;

        case (state_reg)
            F_IDLE:
            begin
                if (req.valid)
                begin
                    ox_next       = req.origin_x;
                    oy_next       = req.origin_y;
                    view_next     = req.view_angle;
                    dividend_next = DW'(req.column) * DW'(fov_span);
                    rem_next      = '0;
                    iter_next     = '0;
                    state_next    = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next      = rem_ge ? CW'(rem_shift - {1'b0, divisor})
                                       : rem_shift[CW-1:0];
                quot_next     = {quot_reg[ANGLE_BITS-2:0], rem_ge};
                dividend_next = dividend_reg << 1;
                iter_next     = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST)
                begin
                    state_next = F_ANGLE;
                end
            end
            F_ANGLE:
            begin
                angle_next = angle_sum[ANGLE_BITS-1:0];
                phase_next = 1'b0;
                state_next = F_PREP;
            end
            F_PREP:
            begin
                x_next     = cur_angle[QBITS] ? grm_pkg::Q14_ONE - x_frac : x_frac;
                neg_next   = cur_angle[ANGLE_BITS-1];
                step_next  = P_SQUARE;
                state_next = F_POLY;
            end
            F_POLY:
            begin
                case (step_reg)
                    P_SQUARE:
                    begin
                        x2_next   = mul_q[MW-1:0];
                        step_next = P_TERM0;
                    end
                    P_TERM0:
                    begin
                        t_next    = grm_pkg::POLY_C1 - mul_q;
                        step_next = P_TERM1;
                    end
                    P_TERM1:
                    begin
                        t_next    = grm_pkg::POLY_C2 - mul_q;
                        step_next = P_TERM2;
                    end
                    P_TERM2:
                    begin
                        t_next    = grm_pkg::POLY_C3 - mul_q;
                        step_next = P_SCALE;
                    end
                    P_SCALE:
                    begin
                        if (!phase_reg)
                        begin
                            sin_next   = trig;
                            phase_next = 1'b1;
                            state_next = F_PREP;
                        end
                        else
                        begin
                            cos_next   = trig;
                            state_next = F_PUSH;
                        end
                    end
                    default:
                    begin
                        step_next = P_SQUARE;
                    end
                endcase
            end
            F_PUSH:
            begin
                if (ray_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= P_SQUARE;
            iter_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            iter_reg  <= iter_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        view_reg     <= view_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        angle_reg    <= angle_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        t_reg        <= t_next;
        neg_reg      <= neg_next;
        sin_reg      <= sin_next;
        cos_reg      <= cos_next;
    end

endmodule

@@ hw/rtl/grm_queue.sv @@
// ----------------------------------------------------------------------------
// grm_queue
// Short FIFO of prepared rays between the front and the marching back end.
// ----------------------------------------------------------------------------
module grm_queue #(
    parameter int DEPTH = grm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  grm_pkg::ray_t push_data,
    input  logic          push_valid,
    output logic          push_ready,
    output grm_pkg::ray_t pop_data,
    output logic          pop_valid,
    input  logic          pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    grm_pkg::ray_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/grm_back.sv @@
// ----------------------------------------------------------------------------
// grm_back
// Marches one ray a unit step per cycle across the wall map and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module grm_back #(
    parameter int CELL_SIZE = grm_pkg::CELL_SIZE_DEF,
    parameter int MAX_STEPS = grm_pkg::MAX_STEPS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  grm_pkg::ray_t              ray,
    input  logic                       ray_valid,
    output logic                       ray_ready,
    input  logic [grm_pkg::WALL_W-1:0] wall_map,
    grm_rsp_if.source                  rsp
);

    localparam int MS       = grm_pkg::MAP_SIZE;
    localparam int TW       = grm_pkg::TRIG_W;
    localparam int HW       = grm_pkg::HIT_W;
    localparam int K_W      = $clog2(MAX_STEPS + 1);
    localparam int ACC_W    = TW + K_W;
    localparam int PX_W     = ACC_W - 7;
    localparam int PXM_W    = PX_W - 1;
    localparam int CELL_Q   = CELL_SIZE << grm_pkg::SUBPIX_W;
    localparam logic [K_W-1:0] K_LAST = K_W'(MAX_STEPS);

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              out_valid_reg, out_valid_next;

    logic [grm_pkg::ORIGIN_W-1:0] ox_reg, ox_next;
    logic [grm_pkg::ORIGIN_W-1:0] oy_reg, oy_next;
    logic signed [TW-1:0]         sin_reg, sin_next;
    logic signed [TW-1:0]         cos_reg, cos_next;
    logic signed [ACC_W-1:0]      accx_reg, accx_next;
    logic signed [ACC_W-1:0]      accy_reg, accy_next;
    logic [HW-1:0]                hit_x_reg, hit_x_next;
    logic [HW-1:0]                hit_y_reg, hit_y_next;
    logic [grm_pkg::DIST_W-1:0]   dist_reg, dist_next;
    grm_pkg::status_t             status_reg, status_next;

    logic signed [PX_W-1:0] px, py;
    logic [PXM_W-1:0]       px_mag, py_mag;
    logic [MS:0]            ge_x, ge_y;
    logic [MS-1:0]          col_hot, row_hot;
    logic                   wall_hit, out_of_map, at_limit, done, load;
    logic [HW-1:0]          sat_x, sat_y;

    assign px = $signed({accx_reg[ACC_W-1], accx_reg[ACC_W-1:8]})
              + $signed({{(PX_W-HW){1'b0}}, ox_reg, {grm_pkg::SUBPIX_W{1'b0}}});
    assign py = $signed({accy_reg[ACC_W-1], accy_reg[ACC_W-1:8]})
              + $signed({{(PX_W-HW){1'b0}}, oy_reg, {grm_pkg::SUBPIX_W{1'b0}}});
    assign px_mag = px[PXM_W-1:0];
    assign py_mag = py[PXM_W-1:0];

    // cell boundaries as a thermometer, turned into one-hot row and column
    always_comb
    begin
        for (int j = 0; j <= MS; j++)
        begin
            ge_x[j] = px_mag >= PXM_W'(j * CELL_Q);
            ge_y[j] = py_mag >= PXM_W'(j * CELL_Q);
        end
        for (int j = 0; j < MS; j++)
        begin
            col_hot[j] = ge_x[j] & ~ge_x[j+1];
            row_hot[j] = ge_y[j] & ~ge_y[j+1];
        end
        wall_hit = 1'b0;
        for (int r = 0; r < MS; r++)
        begin
            for (int c = 0; c < MS; c++)
            begin
                wall_hit = wall_hit | (row_hot[r] & col_hot[c] & wall_map[r*MS + c]);
            end
        end
    end

    assign out_of_map = px[PX_W-1] | py[PX_W-1] | ge_x[MS] | ge_y[MS];
    assign at_limit   = (k_reg == K_LAST);
    assign done       = out_of_map | wall_hit | at_limit;
    assign load       = (state_reg == B_RUN) && done && (!out_valid_reg || rsp.ready);

    assign sat_x = px[PX_W-1] ? '0 : (|px_mag[PXM_W-1:HW]) ? '1 : px_mag[HW-1:0];
    assign sat_y = py[PX_W-1] ? '0 : (|py_mag[PXM_W-1:HW]) ? '1 : py_mag[HW-1:0];

    assign ray_ready    = (state_reg == B_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.hit_x    = hit_x_reg;
    assign rsp.hit_y    = hit_y_reg;
    assign rsp.distance = dist_reg;
    assign rsp.status   = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        hit_x_next     = hit_x_reg;
        hit_y_next     = hit_y_reg;
        dist_next      = dist_reg;
        status_next    = status_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (ray_valid)
                begin
                    ox_next    = ray.origin_x;
                    oy_next    = ray.origin_y;
                    sin_next   = ray.sin_q14;
                    cos_next   = ray.cos_q14;
                    accx_next  = '0;
                    accy_next  = '0;
                    k_next     = '0;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (!done)
                begin
                    k_next    = k_reg + K_W'(1);
                    accx_next = accx_reg + {{(ACC_W-TW){cos_reg[TW-1]}}, cos_reg};
                    accy_next = accy_reg + {{(ACC_W-TW){sin_reg[TW-1]}}, sin_reg};
                end
                else if (load)
                begin
                    out_valid_next = 1'b1;
                    hit_x_next     = sat_x;
                    hit_y_next     = sat_y;
                    dist_next      = k_reg[grm_pkg::DIST_W-1:0];
                    status_next    = out_of_map ? grm_pkg::ST_LEFT_MAP
                                   : wall_hit   ? grm_pkg::ST_WALL
                                                : grm_pkg::ST_STEP_LIMIT;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        sin_reg    <= sin_next;
        cos_reg    <= cos_next;
        accx_reg   <= accx_next;
        accy_reg   <= accy_next;
        hit_x_reg  <= hit_x_next;
        hit_y_reg  <= hit_y_next;
        dist_reg   <= dist_next;
        status_reg <= status_next;
    end

endmodule

@@ hw/rtl/grid_ray_march_unit.sv @@
// ----------------------------------------------------------------------------
// grid_ray_march_unit
// Casts one ray per request over a 16 by 16 wall map and returns the hit
// point, step count and status.
//
//   channel   direction  handshake          payload
//   req       in         valid/ready        origin_x, origin_y, view_angle, column
//   rsp       out        valid/ready        hit_x, hit_y, distance, status
//   cfg       in         cfg_we, no stall   cfg_index, cfg_data
//
// Front: takes no new request until its ray is handed on; a serial divide
// for the column angle, then ten passes through one shared multiplier for
// sine and cosine. Back: one unit step per cycle, and a new ray only once
// the last result is loaded into the output register.
// Reset clears the map and loads the default field of view and column count.
// A full ray queue stalls the front; an untaken result stalls the back.
// ----------------------------------------------------------------------------
module grid_ray_march_unit #(
    parameter int CELL_SIZE   = grm_pkg::CELL_SIZE_DEF,
    parameter int MAX_STEPS   = grm_pkg::MAX_STEPS_DEF,
    parameter int ANGLE_BITS  = grm_pkg::ANGLE_BITS_DEF,
    parameter int QUEUE_DEPTH = grm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    grm_req_if.sink                        req,
    grm_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [grm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grm_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [grm_pkg::MAP_W-1:0]   map_reg [grm_pkg::MAP_REGS];
    logic [grm_pkg::MAP_W-1:0]   map_next [grm_pkg::MAP_REGS];
    logic [grm_pkg::FOV_W-1:0]   fov_reg, fov_next;
    logic [grm_pkg::COUNT_W-1:0] cols_reg, cols_next;
    logic [grm_pkg::WALL_W-1:0]  wall_map;

    grm_pkg::ray_t front_ray, back_ray;
    logic          front_valid, front_ready;
    logic          back_valid, back_ready;

    always_comb
    begin
        map_next  = map_reg;
        fov_next  = fov_reg;
        cols_next = cols_reg;
        if (cfg_we)
        begin
            case (grm_pkg::cfg_reg_t'(cfg_index))
                grm_pkg::REG_MAP_0:   map_next[0] = cfg_data;
                grm_pkg::REG_MAP_1:   map_next[1] = cfg_data;
                grm_pkg::REG_MAP_2:   map_next[2] = cfg_data;
                grm_pkg::REG_MAP_3:   map_next[3] = cfg_data;
                grm_pkg::REG_FOV:     fov_next    = cfg_data[grm_pkg::FOV_W-1:0];
                grm_pkg::REG_COLUMNS: cols_next   = cfg_data[grm_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < grm_pkg::MAP_REGS; i++)
            begin
                map_reg[i] <= '0;
            end
            fov_reg  <= grm_pkg::FOV_RESET;
            cols_reg <= grm_pkg::COUNT_RESET;
        end
        else
        begin
            map_reg  <= map_next;
            fov_reg  <= fov_next;
            cols_reg <= cols_next;
        end
    end

    // bit 16*row + column
    assign wall_map = {map_reg[3], map_reg[2], map_reg[1], map_reg[0]};

    grm_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .fov_span     (fov_reg),
        .column_count (cols_reg),
        .ray          (front_ray),
        .ray_valid    (front_valid),
        .ray_ready    (front_ready)
    );

    grm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_ray),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_ray),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    grm_back #(
        .CELL_SIZE (CELL_SIZE),
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (back_ray),
        .ray_valid (back_valid),
        .ray_ready (back_ready),
        .wall_map  (wall_map),
        .rsp       (rsp)
    );

endmodule

@@ hw/rtl/grm_checker.sv @@
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks on the grid ray march unit: item bookkeeping, result
// hold under stall and the step-limit distance.
// ----------------------------------------------------------------------------
module grm_checker #(
    parameter int MAX_STEPS   = grm_pkg::MAX_STEPS_DEF,
    parameter int QUEUE_DEPTH = grm_pkg::QUEUE_DEPTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [grm_pkg::HIT_W-1:0]    hit_x,
    input logic [grm_pkg::HIT_W-1:0]    hit_y,
    input logic [grm_pkg::DIST_W-1:0]   distance,
    input logic [grm_pkg::STATUS_W-1:0] status
);

    // front, back and output register each hold one
    localparam int CAP    = QUEUE_DEPTH + 3;
    localparam int PEND_W = $clog2(CAP + 2);

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              req_xfer, rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (req_xfer && !rsp_xfer)
        begin
            pend_next = pend_reg + PEND_W'(1);
        end
        else if (rsp_xfer && !req_xfer)
        begin
            pend_next = pend_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_xfer |-> pend_reg != '0)
        else $error("result transfer with no request outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |-> pend_reg < PEND_W'(CAP))
        else $error("request taken beyond internal capacity");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_x) && $stable(hit_y)
                                    && $stable(distance) && $stable(status))
        else $error("stalled result changed");

    a_limit_distance: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == grm_pkg::ST_STEP_LIMIT
            |-> distance == grm_pkg::DIST_W'(MAX_STEPS))
        else $error("step limit reported with wrong distance");

endmodule

bind grid_ray_march_unit grm_checker #(
    .MAX_STEPS   (MAX_STEPS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_grm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .hit_x     (rsp.hit_x),
    .hit_y     (rsp.hit_y),
    .distance  (rsp.distance),
    .status    (rsp.status)
);
